// ----- hdl/llfs_pkg.sv -----
// ----------------------------------------------------------------------------
// llfs_pkg: shared types and constants of the log line field splitter
// Position widths, character codes, level words and small helper functions.
// ----------------------------------------------------------------------------
package llfs_pkg;

  // position and count widths
  localparam int POS_BITS   = 20;
  localparam int EXT_BITS   = POS_BITS + 1;
  localparam int LIMIT_BITS = 21;
  localparam int WIN_DEPTH  = 10;
  localparam int NUM_LEVELS = 8;
  localparam int WORD_MAX   = 9;
  localparam int PADDR_BITS = 3;

  localparam logic [POS_BITS-1:0]   POS_MAX       = {POS_BITS{1'b1}};
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = LIMIT_BITS'(1 << 20);

  // register index of the configuration port
  localparam logic [PADDR_BITS-3:0] REG_RECORD_LIMIT = '0;

  // character codes
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_COLON  = 8'h3a;
  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_LBRACK = 8'h5b;
  localparam logic [7:0] CHAR_RBRACK = 8'h5d;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;
  typedef logic [WORD_MAX-1:0][7:0]  level_word_t;

  // level words, right aligned: char j of a word of length n sits at [n-1-j]
  localparam level_word_t LEVEL_WORD [NUM_LEVELS] = '{
    "EMERGENCY", "CRITICAL", "WARNING", "NOTICE",
    "DEBUG", "ERROR", "ALERT", "INFO"
  };
  localparam logic [3:0] WORD_LEN [NUM_LEVELS] = '{
    4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd5, 4'd5, 4'd4
  };

  // result of the level search at a colon
  typedef struct packed {
    logic                hit;
    logic [2:0]          code;
    logic [POS_BITS-1:0] dot_pos;
  } lvl_hit_t;

  // clamp an extended value to the position range
  function automatic logic [POS_BITS-1:0] fit(input logic [EXT_BITS-1:0] v);
    logic [POS_BITS-1:0] r;
    if (v > {1'b0, POS_MAX}) begin
      r = POS_MAX;
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  // difference that never goes below zero
  function automatic logic [EXT_BITS-1:0] sub_floor(input logic [EXT_BITS-1:0] a,
                                                    input logic [EXT_BITS-1:0] b);
    logic [EXT_BITS-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // next position, saturating at the top of the range
  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    logic [POS_BITS-1:0] r;
    if (v < POS_MAX) begin
      r = v + 1'b1;
    end else begin
      r = POS_MAX;
    end
    return r;
  endfunction

endpackage

// ----- hdl/log_line_field_splitter.sv -----
// ----------------------------------------------------------------------------
// log_line_field_splitter: split log lines into date, channel, level, message
// Byte stream in, at most one record of offsets and lengths out per line.
// ----------------------------------------------------------------------------
// Takes one buffer byte per beat and sustains one beat per clock unless the
// output stalls: a byte is registered at the input, worked through one pass
// of compare and offset logic and lands in the result register, which takes
// a line's record from its last byte (an LF or the byte flagged as the end
// of the buffer). The input register is held only while a finished record
// waits at the output. record_limit (byte address 0) caps the records per
// buffer; all line and position state returns to reset after the last byte.
module log_line_field_splitter import llfs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte input
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_buffer_i,
  // record output
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   matched_o,
  output logic [POS_BITS-1:0]    date_offset_o,
  output logic [POS_BITS-1:0]    date_length_o,
  output logic [POS_BITS-1:0]    channel_offset_o,
  output logic [POS_BITS-1:0]    channel_length_o,
  output logic [2:0]             level_code_o,
  output logic [POS_BITS-1:0]    level_offset_o,
  output logic [POS_BITS-1:0]    message_offset_o,
  output logic [POS_BITS-1:0]    message_length_o,
  output logic                   last_record_o,
  output logic                   position_overflow_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_BITS-1:0]  paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // configuration
  logic [LIMIT_BITS-1:0] limit_q;
  logic                  reg_sel;

  // input register
  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  in_eob_q;

  // buffer and line state
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [POS_BITS-1:0]   ls_q, ls_d;
  logic [LIMIT_BITS-1:0] rec_q, rec_d;
  win_t                  win_q, win_d;
  logic                  ovf_q, ovf_d;
  logic                  brk_q, brk_d;
  logic [POS_BITS-1:0]   brk_pos_q, brk_pos_d;
  logic                  body_q, body_d;
  logic [POS_BITS-1:0]   body_pos_q, body_pos_d;
  logic                  lvl_q, lvl_d;
  logic [POS_BITS-1:0]   dot_q, dot_d;
  logic [2:0]            code_q, code_d;

  // result register
  logic                  out_vld_q;
  logic                  matched_q, matched_d;
  logic [POS_BITS-1:0]   stamp_off_q, stamp_off_d;
  logic [POS_BITS-1:0]   stamp_len_q, stamp_len_d;
  logic [POS_BITS-1:0]   chan_off_q, chan_off_d;
  logic [POS_BITS-1:0]   chan_len_q, chan_len_d;
  logic [2:0]            lcode_q, lcode_d;
  logic [POS_BITS-1:0]   lvl_off_q, lvl_off_d;
  logic [POS_BITS-1:0]   msg_off_q, msg_off_d;
  logic [POS_BITS-1:0]   msg_len_q, msg_len_d;
  logic                  last_q, ovf_out_q;

  logic                  fire;
  logic                  emit;
  lvl_hit_t              lvl_hit;

  // register access
  assign reg_sel = (paddr[PADDR_BITS-1:2] == REG_RECORD_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_q <= pwdata[LIMIT_BITS-1:0];
    end
  end

  // handshake: the work stage moves when the result slot is free or drains
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_eob_q  <= end_of_buffer_i;
    end
  end

  // level search at the current byte
  llfs_level_match u_level_match (
    .win_i      (win_q),
    .pos_i      (pos_q),
    .body_pos_i (body_pos_q),
    .hit_o      (lvl_hit)
  );

  // single pass: scan, record fields and state update
  always_comb begin
    logic                is_lf;
    logic                line_end;
    logic                last;
    logic [7:0]          b;
    logic [7:0]          b1;
    logic [7:0]          b2;
    logic [EXT_BITS-1:0] end_x;
    logic [EXT_BITS-1:0] e1;
    logic [EXT_BITS-1:0] e2;
    logic [EXT_BITS-1:0] ls_x;
    logic [EXT_BITS-1:0] lvl_x;
    logic [EXT_BITS-1:0] msg_x;
    logic                set_brk;
    logic                set_body;
    logic                set_lvl;
    b        = in_byte_q;
    last     = in_eob_q;
    is_lf    = (b == CHAR_LF);
    line_end = is_lf || last;

    brk_d      = brk_q;
    brk_pos_d  = brk_pos_q;
    body_d     = body_q;
    body_pos_d = body_pos_q;
    lvl_d      = lvl_q;
    dot_d      = dot_q;
    code_d     = code_q;

    // pattern pieces of this byte
    set_brk  = !is_lf && !brk_q && (b == CHAR_LBRACK);
    set_body = !is_lf && brk_q && !body_q && (b == CHAR_SPACE) &&
               (win_q[0] == CHAR_RBRACK) && (pos_q > ls_q);
    set_lvl  = body_q && (b == CHAR_COLON) && lvl_hit.hit;
    if (set_brk) begin
      brk_d     = 1'b1;
      brk_pos_d = pos_q;
    end
    if (set_body) begin
      body_d     = 1'b1;
      body_pos_d = sat_inc(pos_q);
    end
    if (set_lvl) begin
      lvl_d  = 1'b1;
      dot_d  = lvl_hit.dot_pos;
      code_d = lvl_hit.code;
    end

    // line end with up to two trailing CR stripped
    ls_x = {1'b0, ls_q};
    if (is_lf) begin
      end_x = {1'b0, pos_q};
      b1    = win_q[0];
      b2    = win_q[1];
    end else begin
      end_x = {1'b0, pos_q} + 1'b1;
      b1    = b;
      b2    = win_q[0];
    end
    e1 = end_x;
    if (e1 > ls_x && b1 == CHAR_CR) begin
      e1 = e1 - 1'b1;
    end
    e2 = e1;
    if (e2 > ls_x && ((e1 == end_x) ? b1 : b2) == CHAR_CR) begin
      e2 = e2 - 1'b1;
    end

    emit = line_end && (rec_q < limit_q) &&
           !(!is_lf && (e1 <= ls_x) && (rec_q != '0));

    // record fields
    lvl_x = {1'b0, dot_d} + 1'b1;
    msg_x = lvl_x + EXT_BITS'(WORD_LEN[code_d]) + 1'b1;
    matched_d   = brk_d && body_d && lvl_d;
    stamp_off_d = '0;
    stamp_len_d = '0;
    chan_off_d  = '0;
    chan_len_d  = '0;
    lcode_d     = '0;
    lvl_off_d   = '0;
    if (matched_d) begin
      stamp_off_d = fit({1'b0, brk_pos_d} + 1'b1);
      stamp_len_d = fit(sub_floor({1'b0, body_pos_d}, {1'b0, brk_pos_d} + 2'd3));
      chan_off_d  = body_pos_d;
      chan_len_d  = fit(sub_floor({1'b0, dot_d}, {1'b0, body_pos_d}));
      lcode_d     = code_d;
      lvl_off_d   = fit(lvl_x);
      msg_off_d   = fit(msg_x);
      msg_len_d   = fit(sub_floor(e2, msg_x));
    end else begin
      msg_off_d   = ls_q;
      msg_len_d   = fit(sub_floor(e1, ls_x));
    end

    // buffer state
    rec_d = emit ? rec_q + 1'b1 : rec_q;
    ls_d  = ls_q;
    if (line_end) begin
      brk_d      = 1'b0;
      brk_pos_d  = '0;
      body_d     = 1'b0;
      body_pos_d = '0;
      lvl_d      = 1'b0;
      dot_d      = '0;
      code_d     = '0;
      ls_d       = sat_inc(pos_q);
    end
    win_d = {win_q[WIN_DEPTH-2:0], b};
    ovf_d = ovf_q;
    pos_d = pos_q;
    if (pos_q >= POS_MAX) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = pos_q + 1'b1;
    end
    if (last) begin
      pos_d = '0;
      ls_d  = '0;
      rec_d = '0;
      win_d = '0;
      ovf_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ls_q       <= '0;
      rec_q      <= '0;
      win_q      <= '0;
      ovf_q      <= 1'b0;
      brk_q      <= 1'b0;
      brk_pos_q  <= '0;
      body_q     <= 1'b0;
      body_pos_q <= '0;
      lvl_q      <= 1'b0;
      dot_q      <= '0;
      code_q     <= '0;
    end else if (fire) begin
      pos_q      <= pos_d;
      ls_q       <= ls_d;
      rec_q      <= rec_d;
      win_q      <= win_d;
      ovf_q      <= ovf_d;
      brk_q      <= brk_d;
      brk_pos_q  <= brk_pos_d;
      body_q     <= body_d;
      body_pos_q <= body_pos_d;
      lvl_q      <= lvl_d;
      dot_q      <= dot_d;
      code_q     <= code_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      matched_q   <= matched_d;
      stamp_off_q <= stamp_off_d;
      stamp_len_q <= stamp_len_d;
      chan_off_q  <= chan_off_d;
      chan_len_q  <= chan_len_d;
      lcode_q     <= lcode_d;
      lvl_off_q   <= lvl_off_d;
      msg_off_q   <= msg_off_d;
      msg_len_q   <= msg_len_d;
      last_q      <= in_eob_q;
      ovf_out_q   <= ovf_q;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign matched_o           = matched_q;
  assign date_offset_o       = stamp_off_q;
  assign date_length_o       = stamp_len_q;
  assign channel_offset_o    = chan_off_q;
  assign channel_length_o    = chan_len_q;
  assign level_code_o        = lcode_q;
  assign level_offset_o      = lvl_off_q;
  assign message_offset_o    = msg_off_q;
  assign message_length_o    = msg_len_q;
  assign last_record_o       = last_q;
  assign position_overflow_o = ovf_out_q;

endmodule

// ----- hdl/llfs_level_match.sv -----
// ----------------------------------------------------------------------------
// llfs_level_match: level word search behind a colon
// Compares the recent byte window against the eight ".LEVEL" patterns and
// picks the first word in table order that fits inside the line body.
// ----------------------------------------------------------------------------
module llfs_level_match import llfs_pkg::*; (
  input  win_t                win_i,
  input  logic [POS_BITS-1:0] pos_i,
  input  logic [POS_BITS-1:0] body_pos_i,
  output lvl_hit_t            hit_o
);

  logic [NUM_LEVELS-1:0] word_ok;

  // per-word compare of the window, plus the body range check
  always_comb begin
    logic [EXT_BITS-1:0] need;
    logic                ok;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      need = {1'b0, body_pos_i} + EXT_BITS'(WORD_LEN[i]) + 1'b1;
      ok   = ({1'b0, pos_i} >= need) && (win_i[WORD_LEN[i]] == CHAR_DOT);
      for (int k = 0; k < WORD_MAX; k++) begin
        if (k < int'(WORD_LEN[i])) begin
          ok = ok && (win_i[k] == LEVEL_WORD[i][k]);
        end
      end
      word_ok[i] = ok;
    end
  end

  // lowest table index wins
  always_comb begin
    hit_o = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (word_ok[i]) begin
        hit_o.hit     = 1'b1;
        hit_o.code    = 3'(i);
        hit_o.dot_pos = pos_i - POS_BITS'(WORD_LEN[i]) - 1'b1;
      end
    end
  end

endmodule
